>>> design/sko_pkg.sv
package sko_pkg;

   localparam int KEY_W = 17;
   localparam int OFS_W = 32;

   typedef logic [1:0] opcode_type;
   typedef logic [1:0] status_type;
   typedef logic [KEY_W-1:0] key_type;
   typedef logic [OFS_W-1:0] ofs_type;

   localparam opcode_type OP_INSERT = 2'd0;
   localparam opcode_type OP_LOOKUP = 2'd1;
   localparam opcode_type OP_DELETE = 2'd2;
   localparam opcode_type OP_UPDATE = 2'd3;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_FULL      = 2'd2;

endpackage

>>> design/sko_mem.sv
module sko_mem #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sko_pkg::key_type    wr_key,
   input  sko_pkg::ofs_type    wr_ofs,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output sko_pkg::key_type    rd_key,
   output sko_pkg::ofs_type    rd_ofs
);

   sko_pkg::key_type key_mem [DEPTH];
   sko_pkg::ofs_type ofs_mem [DEPTH];
   sko_pkg::key_type rd_key_ff;
   sko_pkg::ofs_type rd_ofs_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         ofs_mem[wr_addr] <= wr_ofs;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_ofs_ff <= ofs_mem[rd_addr];
      end
   end

   assign rd_key = rd_key_ff;
   assign rd_ofs = rd_ofs_ff;

endmodule

>>> design/sorted_key_offset_index_unit.sv
// sorted key / offset index: a table of (key, offset) pairs kept in ascending key order
// req channel: one transfer per operation, tdata carries opcode (insert, lookup, delete,
//   update), the key, the replacement key, the record offset and the keep-offset flag
// rsp channel: exactly one transfer per request with status, position, offset and the
//   number of entries left in the table
// one operation at a time: req_tready is high only while the unit is idle
// lookup: midpoint binary search, each probe a read and then a compare through the
//   single read port
// insert, delete, update: the search (not for insert) and then a ripple of entries one
//   slot at a time, each moved entry read and then written; one comparator and one
//   memory do it all
// a full table answers an insert at once with status full and leaves it untouched
// reset empties the table (entry count to zero); the storage itself is not cleared
// the result is held in an output register; while rsp_tready is low the unit simply
//   waits with rsp_tvalid high and takes no new request
module sorted_key_offset_index_unit #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode, lookup_key, replacement_key, record_offset, keep_offset
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, position, found_offset, entry_count
   output logic [55:0] rsp_tdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = AW + 2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SRD    = 4'd1;
   localparam logic [3:0] S_SCMP   = 4'd2;
   localparam logic [3:0] S_LRD    = 4'd3;
   localparam logic [3:0] S_LCMP   = 4'd4;
   localparam logic [3:0] S_RRD    = 4'd5;
   localparam logic [3:0] S_RCMP   = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;

   // request fields
   sko_pkg::opcode_type req_opcode;
   sko_pkg::key_type    req_lookup_key;
   sko_pkg::key_type    req_replacement_key;
   sko_pkg::ofs_type    req_record_offset;
   logic                req_keep_offset;

   assign req_opcode          = req_tdata[1:0];
   assign req_lookup_key      = req_tdata[18:2];
   assign req_replacement_key = req_tdata[35:19];
   assign req_record_offset   = req_tdata[67:36];
   assign req_keep_offset     = req_tdata[68];

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       cur_ff, cur_in;       // working slot of the ripple
   logic signed [SW-1:0] low_ff, low_in, high_ff, high_in;
   sko_pkg::opcode_type op_ff, op_in;
   sko_pkg::key_type    ref_ff, ref_in;       // key being compared against
   sko_pkg::key_type    new_key_ff, new_key_in;
   sko_pkg::ofs_type    ofs_ff, ofs_in;
   logic                keep_ff, keep_in;
   logic                moved_ff, moved_in;
   sko_pkg::status_type st_ff, st_in;
   logic [CW-1:0]       pos_ff, pos_in;
   sko_pkg::ofs_type    fofs_ff, fofs_in;

   // memory port
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   sko_pkg::key_type    wr_key, rd_key;
   sko_pkg::ofs_type    wr_ofs, rd_ofs;

   sko_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_ofs  (wr_ofs),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_ofs  (rd_ofs)
   );

   // shared datapath: one midpoint adder, one key comparator, one slot incrementer
   logic [SW-1:0] mid_sum;
   logic [AW-1:0] mid_idx;
   logic          key_eq, key_lt, key_gt;
   logic [CW:0]   cur_next;
   logic          at_end;

   assign mid_sum  = low_ff + high_ff;
   assign mid_idx  = mid_sum[AW:1];
   assign key_eq   = (rd_key == ref_ff);
   assign key_lt   = (rd_key < ref_ff);
   assign key_gt   = !key_eq && !key_lt;
   assign cur_next = (CW+1)'(cur_ff) + (CW+1)'(1);
   assign at_end   = (cur_next >= (CW+1)'(count_ff));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      op_in      = op_ff;
      ref_in     = ref_ff;
      new_key_in = new_key_ff;
      ofs_in     = ofs_ff;
      keep_in    = keep_ff;
      moved_in   = moved_ff;
      st_in      = st_ff;
      pos_in     = pos_ff;
      fofs_in    = fofs_ff;
      wr_en      = 1'b0;
      wr_addr    = cur_ff[AW-1:0];
      wr_key     = ref_ff;
      wr_ofs     = ofs_ff;
      rd_en      = 1'b0;
      rd_addr    = mid_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_opcode;
               ref_in     = req_lookup_key;
               new_key_in = req_replacement_key;
               ofs_in     = req_record_offset;
               keep_in    = req_keep_offset;
               moved_in   = 1'b0;
               st_in      = sko_pkg::ST_OK;
               pos_in     = '0;
               fofs_in    = '0;
               low_in     = '0;
               high_in    = SW'(count_ff) - SW'(1);
               if (req_opcode == sko_pkg::OP_INSERT) begin
                  if (count_ff == CW'(TABLE_DEPTH)) begin
                     st_in    = sko_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     // start at the empty slot past the end and ripple left
                     cur_in   = count_ff;
                     count_in = count_ff + CW'(1);
                     state_in = S_LRD;
                  end
               end else begin
                  state_in = S_SRD;
               end
            end
         end
         S_SRD: begin
            if (low_ff > high_ff) begin
               st_in    = sko_pkg::ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = mid_idx;
               cur_in   = CW'(mid_idx);
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (key_eq) begin
               pos_in  = cur_ff;
               fofs_in = rd_ofs;
               case (op_ff)
                  sko_pkg::OP_LOOKUP: state_in = S_RESP;
                  sko_pkg::OP_DELETE: state_in = S_RRD;
                  default: begin
                     // update: carry the new key (with the kept or new offset) left or right to restore order
                     ref_in   = new_key_ff;
                     ofs_in   = keep_ff ? rd_ofs : ofs_ff;
                     state_in = S_LRD;
                  end
               endcase
            end else if (key_lt) begin
               low_in   = SW'(mid_idx) + SW'(1);
               state_in = S_SRD;
            end else begin
               high_in  = SW'(mid_idx) - SW'(1);
               state_in = S_SRD;
            end
         end
         S_LRD: begin
            if (cur_ff == '0) begin
               if (op_ff == sko_pkg::OP_UPDATE && !moved_ff) begin
                  state_in = S_RRD;
               end else begin
                  wr_en    = 1'b1;
                  pos_in   = cur_ff;
                  fofs_in  = ofs_ff;
                  state_in = S_RESP;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(cur_ff - CW'(1));
               state_in = S_LCMP;
            end
         end
         S_LCMP: begin
            if (key_gt) begin
               // larger neighbour shifts one slot right
               wr_en    = 1'b1;
               wr_key   = rd_key;
               wr_ofs   = rd_ofs;
               cur_in   = cur_ff - CW'(1);
               moved_in = 1'b1;
               state_in = S_LRD;
            end else if (op_ff == sko_pkg::OP_UPDATE && !moved_ff) begin
               state_in = S_RRD;
            end else begin
               wr_en    = 1'b1;
               pos_in   = cur_ff;
               fofs_in  = ofs_ff;
               state_in = S_RESP;
            end
         end
         S_RRD: begin
            if (at_end) begin
               if (op_ff == sko_pkg::OP_DELETE) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  wr_en   = 1'b1;
                  pos_in  = cur_ff;
                  fofs_in = ofs_ff;
               end
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cur_next[AW-1:0];
               state_in = S_RCMP;
            end
         end
         S_RCMP: begin
            if (op_ff == sko_pkg::OP_DELETE || key_lt) begin
               // smaller neighbour (or any, on delete) shifts one slot left
               wr_en    = 1'b1;
               wr_key   = rd_key;
               wr_ofs   = rd_ofs;
               cur_in   = cur_next[CW-1:0];
               state_in = S_RRD;
            end else begin
               wr_en    = 1'b1;
               pos_in   = cur_ff;
               fofs_in  = ofs_ff;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cur_ff     <= cur_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      op_ff      <= op_in;
      ref_ff     <= ref_in;
      new_key_ff <= new_key_in;
      ofs_ff     <= ofs_in;
      keep_ff    <= keep_in;
      moved_ff   <= moved_in;
      st_ff      <= st_in;
      pos_ff     <= pos_in;
      fofs_ff    <= fofs_in;
   end

   logic [31:0] pos_wide, count_wide;
   assign pos_wide   = 32'(pos_ff);
   assign count_wide = 32'(count_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {7'd0, count_wide[7:0], fofs_ff, pos_wide[6:0], st_ff};

endmodule

>>> design/sko_checker.sv
module sko_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // held result stays until taken
   ap_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // an accepted request makes the unit busy
   ap_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // no request taken while a result is pending
   ap_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready with a result pending");

   // one result per request
   ap_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("repeated result");

   ap_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("illegal status code");

endmodule

bind sorted_key_offset_index_unit sko_checker u_sko_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/tb_sorted_key_offset_index_unit.sv
module tb_sorted_key_offset_index_unit;

   localparam int DEPTH = 128;
   localparam int LIMIT_CYCLES = 3000000;

   typedef struct packed {
      logic                keep;
      sko_pkg::ofs_type    ofs;
      sko_pkg::key_type    new_key;
      sko_pkg::key_type    key;
      sko_pkg::opcode_type op;
   } index_req_type;

   typedef struct packed {
      logic [7:0]          count;
      sko_pkg::ofs_type    ofs;
      logic [6:0]          pos;
      sko_pkg::status_type status;
   } index_rsp_type;

   typedef struct {
      index_req_type req;
      logic          typed;
      index_rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   // index model state
   int               model_count;
   sko_pkg::key_type model_key[DEPTH];
   sko_pkg::ofs_type model_ofs[DEPTH];

   index_rsp_type pending_rsp[$];
   stim_row_type  directed_rows[$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;
   int cycle_count = 0;

   sorted_key_offset_index_unit #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

   always #4 clock = ~clock;

   function automatic int search_key(sko_pkg::key_type k);
      int lo, hi, mid;
      lo = 0;
      hi = model_count - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (model_key[mid] == k) return mid;
         if (model_key[mid] < k) lo = mid + 1;
         else hi = mid - 1;
      end
      return -1;
   endfunction

   function automatic void drop_entry(int p);
      for (int i = p; i + 1 < model_count; i++) begin
         model_key[i] = model_key[i+1];
         model_ofs[i] = model_ofs[i+1];
      end
      model_count--;
   endfunction

   function automatic void place_entry(int p, sko_pkg::key_type k, sko_pkg::ofs_type o);
      for (int i = model_count; i > p; i--) begin
         model_key[i] = model_key[i-1];
         model_ofs[i] = model_ofs[i-1];
      end
      model_key[p] = k;
      model_ofs[p] = o;
      model_count++;
   endfunction

   // applies one operation to the model table and returns the answer
   function automatic index_rsp_type apply_index_op(index_req_type r);
      index_rsp_type a;
      int f, p, tgt;
      sko_pkg::ofs_type o;
      a = '0;
      a.status = sko_pkg::ST_OK;
      if (r.op == sko_pkg::OP_INSERT) begin
         if (model_count >= DEPTH) begin
            a.status = sko_pkg::ST_FULL;
         end else begin
            p = 0;
            while (p < model_count && model_key[p] <= r.key) p++;
            place_entry(p, r.key, r.ofs);
            a.pos = p[6:0];
            a.ofs = r.ofs;
         end
      end else begin
         f = search_key(r.key);
         if (f < 0) begin
            a.status = sko_pkg::ST_NOT_FOUND;
         end else if (r.op == sko_pkg::OP_LOOKUP) begin
            a.pos = f[6:0];
            a.ofs = model_ofs[f];
         end else if (r.op == sko_pkg::OP_DELETE) begin
            a.pos = f[6:0];
            a.ofs = model_ofs[f];
            drop_entry(f);
         end else begin
            o = r.keep ? model_ofs[f] : r.ofs;
            tgt = 0;
            for (int i = 0; i < model_count; i++)
               if (i != f && (model_key[i] < r.new_key ||
                              (model_key[i] == r.new_key && i < f)))
                  tgt++;
            drop_entry(f);
            place_entry(tgt, r.new_key, o);
            a.pos = tgt[6:0];
            a.ofs = o;
         end
      end
      a.count = model_count[7:0];
      return a;
   endfunction

   // random key taken from the table most of the time so searches hit
   function automatic sko_pkg::key_type pick_key();
      if (model_count > 0 && $urandom_range(0, 99) < 60)
         return model_key[$urandom_range(0, model_count - 1)];
      case ($urandom_range(0, 9))
         0: return sko_pkg::key_type'($urandom_range(0, 131071));
         1: return 17'h1FFFF;
         2: return '0;
         default: return sko_pkg::key_type'($urandom_range(0, 63));
      endcase
   endfunction

   function automatic index_req_type random_req();
      index_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      // lean towards inserts while the table is small, away from them when it is nearly full
      if (model_count < 20)
         r.op = (pick < 55) ? sko_pkg::OP_INSERT
                            : sko_pkg::opcode_type'($urandom_range(1, 3));
      else if (model_count > 110)
         r.op = (pick < 15) ? sko_pkg::OP_INSERT
                            : sko_pkg::opcode_type'($urandom_range(1, 3));
      else r.op = sko_pkg::opcode_type'($urandom_range(0, 3));
      r.key = pick_key();
      r.new_key = ($urandom_range(0, 3) == 0) ? r.key : pick_key();
      r.ofs = sko_pkg::ofs_type'($urandom());
      r.keep = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic index_req_type mk(sko_pkg::opcode_type op, sko_pkg::key_type k,
                                        sko_pkg::key_type nk, sko_pkg::ofs_type o,
                                        logic kp);
      index_req_type r;
      r.op = op;
      r.key = k;
      r.new_key = nk;
      r.ofs = o;
      r.keep = kp;
      return r;
   endfunction

   function automatic void add_row(index_req_type r, logic typed, index_rsp_type e);
      stim_row_type s;
      s.req = r;
      s.typed = typed;
      s.rsp = e;
      directed_rows.push_back(s);
   endfunction

   function automatic index_rsp_type ans(sko_pkg::status_type st, int p,
                                         sko_pkg::ofs_type o, int c);
      index_rsp_type a;
      a.status = st;
      a.pos = p[6:0];
      a.ofs = o;
      a.count = c[7:0];
      return a;
   endfunction

   // tvalid stays high after a transfer; the next call lowers or reloads it, or drain takes it down
   task automatic send_req(index_req_type r, logic typed, index_rsp_type e);
      index_rsp_type p;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      p = apply_index_op(r);
      if (typed && p !== e) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("table row disagrees with model: row %h model %h", e, p);
      end
      pending_rsp.push_back(p);
      req_tvalid <= 1'b1;
      req_tdata <= 72'(r);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // result side: stalls at random, or holds off completely when asked
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               index_rsp_type e;
               e = pending_rsp.pop_front();
               if (rsp_tdata !== 56'(e)) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result mismatch: expected %h actual %h", 56'(e), rsp_tdata);
               end
            end
         end
         rsp_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      index_rsp_type none;
      none = '0;
      model_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: every search misses; then inserts fill it
      add_row(mk(sko_pkg::OP_LOOKUP, 17'd5, 17'd0, 32'd0, 1'b0), 1'b1,
              ans(sko_pkg::ST_NOT_FOUND, 0, 0, 0));
      add_row(mk(sko_pkg::OP_DELETE, 17'd0, 17'd0, 32'd0, 1'b0), 1'b1,
              ans(sko_pkg::ST_NOT_FOUND, 0, 0, 0));
      add_row(mk(sko_pkg::OP_UPDATE, 17'h1FFFF, 17'd0, 32'd1, 1'b0), 1'b1,
              ans(sko_pkg::ST_NOT_FOUND, 0, 0, 0));
      add_row(mk(sko_pkg::OP_INSERT, 17'd50, 17'd0, 32'hFFFFFFFF, 1'b0), 1'b1,
              ans(sko_pkg::ST_OK, 0, 32'hFFFFFFFF, 1));
      add_row(mk(sko_pkg::OP_INSERT, 17'd0, 17'd0, 32'd0, 1'b0), 1'b1,
              ans(sko_pkg::ST_OK, 0, 0, 2));
      add_row(mk(sko_pkg::OP_INSERT, 17'h1FFFF, 17'd0, 32'h12345678, 1'b0), 1'b1,
              ans(sko_pkg::ST_OK, 2, 32'h12345678, 3));
      add_row(mk(sko_pkg::OP_INSERT, 17'd99999, 17'd0, 32'hA5A5A5A5, 1'b0), 1'b1,
              ans(sko_pkg::ST_OK, 2, 32'hA5A5A5A5, 4));
      // duplicate keys land after the equal ones; lookups, updates and deletes follow
      add_row(mk(sko_pkg::OP_INSERT, 17'd50, 17'd0, 32'd7, 1'b0), 1'b0, none);
      add_row(mk(sko_pkg::OP_INSERT, 17'd50, 17'd0, 32'd8, 1'b0), 1'b0, none);
      add_row(mk(sko_pkg::OP_LOOKUP, 17'd50, 17'd0, 32'd0, 1'b1), 1'b0, none);
      add_row(mk(sko_pkg::OP_LOOKUP, 17'h1FFFF, 17'd0, 32'd0, 1'b0), 1'b0, none);
      add_row(mk(sko_pkg::OP_LOOKUP, 17'd51, 17'd0, 32'd0, 1'b0), 1'b0, none);
      add_row(mk(sko_pkg::OP_UPDATE, 17'd50, 17'd50, 32'd9, 1'b1), 1'b0, none);
      add_row(mk(sko_pkg::OP_UPDATE, 17'd50, 17'd3, 32'h5A5A5A5A, 1'b0), 1'b0, none);
      add_row(mk(sko_pkg::OP_UPDATE, 17'd0, 17'h1FFFF, 32'd0, 1'b1), 1'b0, none);
      add_row(mk(sko_pkg::OP_DELETE, 17'h1FFFF, 17'd0, 32'd0, 1'b0), 1'b0, none);
      add_row(mk(sko_pkg::OP_DELETE, 17'd99999, 17'h1FFFF, 32'hFFFFFFFF, 1'b1), 1'b0, none);
      add_row(mk(sko_pkg::OP_DELETE, 17'd12345, 17'd0, 32'd0, 1'b0), 1'b0, none);
      foreach (directed_rows[i])
         send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      drain();

      // fill to the brim, then a full-table insert
      while (model_count < DEPTH)
         send_req(mk(sko_pkg::OP_INSERT, sko_pkg::key_type'($urandom_range(0, 131071)),
                     17'd0, sko_pkg::ofs_type'($urandom()), 1'b0), 1'b0, none);
      send_req(mk(sko_pkg::OP_INSERT, 17'd1, 17'd0, 32'hFFFFFFFF, 1'b1), 1'b1,
               ans(sko_pkg::ST_FULL, 0, 0, DEPTH));
      // receiver holds off for a long stretch while requests keep coming
      fork
         begin
            hold_off = 1'b1;
            repeat (2000) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            repeat (6) send_req(random_req(), 1'b0, none);
            drain();
         end
      join
      drain();
      while (model_count > 10)
         send_req(mk(sko_pkg::OP_DELETE, model_key[$urandom_range(0, model_count - 1)],
                     17'd0, 32'd0, 1'b0), 1'b0, none);
      drain();

      // random phases with different idling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 52; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         repeat (150) send_req(random_req(), 1'b0, none);
      end
      drain();
      repeat (400) @(posedge clock);
      if (mismatch_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule
